// ----- design/mcw4s2_pkg.sv -----
package mcw4s2_pkg;

   localparam int MAX_COLUMNS  = 1024;
   localparam int MAX_CHANNELS = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_ROWS     = 4096;

   localparam int COL_BITS       = $clog2(MAX_COLUMNS);
   localparam int CH_BITS        = 4;
   localparam int CH_ADDR_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ROW_BITS       = 12;
   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 13;
   localparam int CHANS_BITS     = 5;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;

   localparam int LINE_DEPTH     = MAX_COLUMNS * MAX_CHANNELS;
   localparam int LINE_ADDR_BITS = COL_BITS + CH_ADDR_BITS;
   localparam int LINE_BITS      = 3 * 16;
   localparam int WIN_BITS       = 16 * 16;
   localparam int TILE_ROW_BITS  = 4 * 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

   typedef struct packed {
      logic                      en;
      logic [LINE_ADDR_BITS-1:0] addr;
      logic [LINE_BITS-1:0]      data;
   } line_wr_type;

   typedef struct packed {
      logic                    en;
      logic [CH_ADDR_BITS-1:0] addr;
      logic [WIN_BITS-1:0]     data;
   } win_wr_type;

   function automatic logic [15:0] norm_sample(input logic [15:0] raw);
      logic signed [SAMPLE_BITS-1:0] v;
      v = raw[SAMPLE_BITS-1:0];
      return 16'(v);
   endfunction

endpackage

// ----- design/multichannel_4x4_window_stride2.sv -----
// Takes one channel sample per item, pixels in raster order with their channels in sequence,
// and after the last channel of every pixel with odd row and column of at least three sends
// one 4x4 tile per channel, channel zero first, the final one marked by last_tile. An item
// first reads the line store and the window store, then writes both back; the line store
// is a single-port-per-direction memory holding the three previous rows of every column
// and channel. Each tile then needs a window store read and then the output state, which
// rsp_stall can hold. After reset all 16384 entries of the line store are cleared, during
// which req_stall stays high; configuration writes are taken at any time but should only
// be made while the block is idle.
module multichannel_4x4_window_stride2 (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [15:0]                         req_sample,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [mcw4s2_pkg::TILE_ROW_BITS-1:0]       rsp_tile_row0,
   output logic [mcw4s2_pkg::TILE_ROW_BITS-1:0]       rsp_tile_row1,
   output logic [mcw4s2_pkg::TILE_ROW_BITS-1:0]       rsp_tile_row2,
   output logic [mcw4s2_pkg::TILE_ROW_BITS-1:0]       rsp_tile_row3,
   output logic [mcw4s2_pkg::CH_BITS-1:0]             rsp_tile_channel,
   output logic                                       rsp_last_tile,
   input  logic                                       csr_wr_en,
   input  logic [mcw4s2_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [mcw4s2_pkg::CSR_DATA_BITS-1:0]       csr_wr_data
);
   import mcw4s2_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_TREAD  = 5'b01000,
      ST_TSEND  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [WIDTH_BITS-1:0]     width_ff;
   logic [HEIGHT_BITS-1:0]    height_ff;
   logic [CHANS_BITS-1:0]     chans_ff;
   logic [CH_BITS-1:0]        ch_cnt_ff, ch_cnt_in;
   logic [COL_BITS-1:0]       col_cnt_ff, col_cnt_in;
   logic [ROW_BITS-1:0]       row_cnt_ff, row_cnt_in;
   logic [CH_BITS-1:0]        cur_ch_ff;
   logic [COL_BITS-1:0]       cur_col_ff;
   logic [15:0]               sample_ff;
   logic [CH_BITS-1:0]        tile_k_ff, tile_k_in;
   logic [LINE_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   logic [WIDTH_BITS-1:0]     w_eff;
   logic [HEIGHT_BITS-1:0]    h_eff;
   logic [CHANS_BITS-1:0]     nch_eff;
   logic [CH_BITS-1:0]        ch_eff;
   logic [COL_BITS-1:0]       col_eff;
   logic                      req_accept;
   logic                      rsp_accept;
   logic                      pix_end;
   logic                      emit;
   logic                      tile_last;

   line_wr_type               line_wr;
   win_wr_type                win_wr;
   logic [LINE_BITS-1:0]      line_rd;
   logic [WIN_BITS-1:0]       win_rd;
   logic [WIN_BITS-1:0]       win_new;
   logic [15:0]               new_col [4];
   logic                      win_rd_en;
   logic [CH_ADDR_BITS-1:0]   win_rd_addr;

   // Registers of zero act as one, and oversized ones saturate.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_BITS'(MAX_COLUMNS)) begin
         w_eff = WIDTH_BITS'(MAX_COLUMNS);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_BITS'(1);
      end else if (height_ff > HEIGHT_BITS'(MAX_ROWS)) begin
         h_eff = HEIGHT_BITS'(MAX_ROWS);
      end else begin
         h_eff = height_ff;
      end
      if (chans_ff == '0) begin
         nch_eff = CHANS_BITS'(1);
      end else if (chans_ff > CHANS_BITS'(MAX_CHANNELS)) begin
         nch_eff = CHANS_BITS'(MAX_CHANNELS);
      end else begin
         nch_eff = chans_ff;
      end
   end

   assign ch_eff  = ({1'b0, ch_cnt_ff} >= nch_eff) ? CH_BITS'(nch_eff - 1'b1) : ch_cnt_ff;
   assign col_eff = ({1'b0, col_cnt_ff} >= w_eff) ? COL_BITS'(w_eff - 1'b1) : col_cnt_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_TSEND);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign pix_end   = (CHANS_BITS'(cur_ch_ff) + CHANS_BITS'(1)) >= nch_eff;
   assign emit      = row_cnt_ff[0] && (row_cnt_ff >= ROW_BITS'(3))
                      && cur_col_ff[0] && (cur_col_ff >= COL_BITS'(3));
   assign tile_last = (CHANS_BITS'(tile_k_ff) + CHANS_BITS'(1)) >= nch_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1024);
         height_ff <= HEIGHT_BITS'(1024);
         chans_ff  <= CHANS_BITS'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   width_ff  <= csr_wr_data[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_wr_data[HEIGHT_BITS-1:0];
            REG_CHANNEL_COUNT: chans_ff  <= csr_wr_data[CHANS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      ch_cnt_in   = ch_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      tile_k_in   = tile_k_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LINE_ADDR_BITS'(LINE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            tile_k_in = '0;
            if (!pix_end) begin
               ch_cnt_in = cur_ch_ff + 1'b1;
               state_in  = ST_IDLE;
            end else begin
               ch_cnt_in = '0;
               if (({1'b0, cur_col_ff} + WIDTH_BITS'(1)) >= w_eff) begin
                  col_cnt_in = '0;
                  if (({1'b0, row_cnt_ff} + HEIGHT_BITS'(1)) >= h_eff) begin
                     row_cnt_in = '0;
                  end else begin
                     row_cnt_in = row_cnt_ff + 1'b1;
                  end
               end else begin
                  col_cnt_in = cur_col_ff + 1'b1;
               end
               state_in = emit ? ST_TREAD : ST_IDLE;
            end
         end
         ST_TREAD: begin
            state_in = ST_TSEND;
         end
         ST_TSEND: begin
            if (rsp_accept) begin
               if (tile_last) begin
                  state_in = ST_IDLE;
               end else begin
                  tile_k_in = tile_k_ff + 1'b1;
                  state_in  = ST_TREAD;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         ch_cnt_ff   <= '0;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         tile_k_ff   <= '0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         ch_cnt_ff   <= ch_cnt_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         tile_k_ff   <= tile_k_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff  <= norm_sample(req_sample);
         cur_ch_ff  <= ch_eff;
         cur_col_ff <= col_eff;
      end
   end

   // The stored column shifts up by one row and the new sample enters at the bottom.
   assign new_col[0] = line_rd[15:0];
   assign new_col[1] = line_rd[31:16];
   assign new_col[2] = line_rd[47:32];
   assign new_col[3] = sample_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         win_new[r*TILE_ROW_BITS +: TILE_ROW_BITS] =
            {new_col[r], win_rd[r*TILE_ROW_BITS+16 +: TILE_ROW_BITS-16]};
      end
   end

   always_comb begin
      line_wr = '0;
      if (state_ff == ST_CLEAR) begin
         line_wr.en   = 1'b1;
         line_wr.addr = clr_addr_ff;
      end else if (state_ff == ST_UPDATE) begin
         line_wr.en   = 1'b1;
         line_wr.addr = {cur_col_ff, CH_ADDR_BITS'(cur_ch_ff)};
         line_wr.data = {sample_ff, line_rd[47:32], line_rd[31:16]};
      end
   end

   always_comb begin
      win_wr      = '0;
      win_wr.en   = (state_ff == ST_UPDATE);
      win_wr.addr = CH_ADDR_BITS'(cur_ch_ff);
      win_wr.data = win_new;
   end

   assign win_rd_en   = req_accept || (state_ff == ST_TREAD);
   assign win_rd_addr = (state_ff == ST_TREAD) ? CH_ADDR_BITS'(tile_k_ff)
                                               : CH_ADDR_BITS'(ch_eff);

   mcw4s2_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr ({col_eff, CH_ADDR_BITS'(ch_eff)}),
      .wr      (line_wr),
      .rd_data (line_rd)
   );

   mcw4s2_win_mem u_win_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (win_rd_en),
      .rd_addr (win_rd_addr),
      .wr      (win_wr),
      .rd_data (win_rd)
   );

   assign rsp_tile_row0    = win_rd[0*TILE_ROW_BITS +: TILE_ROW_BITS];
   assign rsp_tile_row1    = win_rd[1*TILE_ROW_BITS +: TILE_ROW_BITS];
   assign rsp_tile_row2    = win_rd[2*TILE_ROW_BITS +: TILE_ROW_BITS];
   assign rsp_tile_row3    = win_rd[3*TILE_ROW_BITS +: TILE_ROW_BITS];
   assign rsp_tile_channel = tile_k_ff;
   assign rsp_last_tile    = tile_last;

   a_item_blocks_next: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_UPDATE) && req_stall)
      else $error("an accepted item did not move to the write-back cycle");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_tile) |=> !rsp_valid && !req_stall)
      else $error("the tile burst did not end after the final tile");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_tile_channel} < nch_eff))
      else $error("tile channel beyond the channel count");

   a_burst_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && pix_end && emit) |=> (tile_k_ff == '0) && !rsp_valid)
      else $error("tile burst did not start at channel zero");

endmodule

// ----- design/mcw4s2_line_mem.sv -----
module mcw4s2_line_mem (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [mcw4s2_pkg::LINE_ADDR_BITS-1:0] rd_addr,
   input  mcw4s2_pkg::line_wr_type              wr,
   output logic [mcw4s2_pkg::LINE_BITS-1:0]      rd_data
);
   import mcw4s2_pkg::*;

   logic [LINE_BITS-1:0] mem [LINE_DEPTH];
   logic [LINE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/mcw4s2_win_mem.sv -----
module mcw4s2_win_mem (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [mcw4s2_pkg::CH_ADDR_BITS-1:0] rd_addr,
   input  mcw4s2_pkg::win_wr_type             wr,
   output logic [mcw4s2_pkg::WIN_BITS-1:0]     rd_data
);
   import mcw4s2_pkg::*;

   // A window that has never been written reads as all zero.
   logic [WIN_BITS-1:0]     mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] valid_ff;
   logic [WIN_BITS-1:0]     rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
